### rtl/lmsd_pkg.sv
// Shared types and constants of the log message stream deframer.
package lmsd_pkg;

    // Header checks
    localparam int unsigned HDR_IDX_W   = 4;
    localparam int unsigned MAGIC_BYTES = 7;
    localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h55, 8'h4C, 8'h6F, 8'h67,
                                                   8'h01, 8'h12, 8'h35};
    localparam logic [7:0] LOG_VERSION = 8'h01;

    // Message types with special handling
    localparam logic [7:0] TYPE_FLAGS   = 8'h42;  // 'B'
    localparam logic [7:0] TYPE_SUB     = 8'h41;  // 'A'
    localparam logic [7:0] TYPE_DATA    = 8'h44;  // 'D'
    localparam logic [7:0] TYPE_DROPOUT = 8'h4F;  // 'O'

    // Minimum payload lengths
    localparam logic [15:0] FLAGS_MIN_LEN = 16'd40;
    localparam logic [15:0] SUB_MIN_LEN   = 16'd3;
    localparam logic [15:0] DATA_MIN_LEN  = 16'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_TRUNCATED   = 3'd3;
    localparam logic [2:0] ST_FLAGS_SHORT = 3'd4;
    localparam logic [2:0] ST_INCOMPAT    = 3'd5;
    localparam logic [2:0] ST_SUB_SHORT   = 3'd6;
    localparam logic [2:0] ST_DATA_SHORT  = 3'd7;

    // Result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  msg_type;
        logic [15:0] length;
        logic [15:0] msg_id;
        logic [7:0]  instance_id;
        logic [2:0]  status;
        logic [31:0] dropouts;
        logic        last;
    } lmsd_result_t;

    // Up to two results written per accepted item
    typedef struct packed {
        logic [1:0]   count;
        lmsd_result_t first;
        lmsd_result_t second;
    } lmsd_wr_t;

endpackage

### rtl/lmsd_parser.sv
// Byte-level parser: header check, message framing and result generation.
module lmsd_parser
    import lmsd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output lmsd_wr_t   wr
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN0,
        PH_LEN1,
        PH_TYPE,
        PH_PAYLOAD
    } phase_t;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

    phase_t                phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]  hidx_reg, hidx_next;
    logic [15:0]           len_reg, len_next;
    logic [7:0]            type_reg, type_next;
    logic [15:0]           pcnt_reg, pcnt_next;
    logic [15:0]           id_reg, id_next;
    logic [7:0]            inst_reg, inst_next;
    logic                  flags_reg, flags_next;
    logic [31:0]           drop_reg, drop_next;
    logic                  failed_reg, failed_next;
    logic [1:0]            fault_reg, fault_next;

    logic                  done;
    logic                  hdr_err;
    logic                  err;
    logic [2:0]            msg_status;
    logic [15:0]           msg_id;
    logic [7:0]            msg_inst;
    logic                  have_sum;
    lmsd_result_t          rpt;
    lmsd_result_t          sum;

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        pcnt_next   = pcnt_reg;
        id_next     = id_reg;
        inst_next   = inst_reg;
        flags_next  = flags_reg;
        drop_next   = drop_reg;
        failed_next = failed_reg;
        fault_next  = fault_reg;
        done        = 1'b0;
        hdr_err     = 1'b0;
        msg_status  = ST_OK;
        msg_id      = '0;
        msg_inst    = '0;
        wr          = '0;
        rpt         = '0;
        sum         = '0;
        have_sum    = 1'b0;
        err         = 1'b0;

        if (take && !failed_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hidx_reg < HDR_IDX_W'(MAGIC_BYTES) && fault_reg == 2'd0 &&
                        data_byte != MAGIC[hidx_reg[2:0]])
                    begin
                        fault_next = ST_BAD_MAGIC[1:0];
                    end
                    if (hidx_reg == HDR_IDX_W'(MAGIC_BYTES) && fault_reg == 2'd0 &&
                        data_byte != LOG_VERSION)
                    begin
                        fault_next = ST_BAD_VERSION[1:0];
                    end
                    if (hidx_reg == HDR_LAST)
                    begin
                        if (fault_next != 2'd0)
                            hdr_err = 1'b1;
                        else
                            phase_next = PH_LEN0;
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 1'b1;
                    end
                end
                PH_LEN0:
                begin
                    len_next   = {8'd0, data_byte};
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_next   = {data_byte, len_reg[7:0]};
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = data_byte;
                    pcnt_next  = '0;
                    id_next    = '0;
                    inst_next  = '0;
                    flags_next = 1'b0;
                    if (len_reg == 16'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // pick identifiers and the incompatible-flags word out of the payload
                    if (type_reg == TYPE_SUB)
                    begin
                        if (pcnt_reg == 16'd0)
                            inst_next = data_byte;
                        else if (pcnt_reg == 16'd1)
                            id_next = {id_reg[15:8], data_byte};
                        else if (pcnt_reg == 16'd2)
                            id_next = {data_byte, id_reg[7:0]};
                    end
                    else if (type_reg == TYPE_DATA)
                    begin
                        if (pcnt_reg == 16'd0)
                            id_next = {id_reg[15:8], data_byte};
                        else if (pcnt_reg == 16'd1)
                            id_next = {data_byte, id_reg[7:0]};
                    end
                    else if (type_reg == TYPE_FLAGS)
                    begin
                        if (pcnt_reg inside {[16'd8:16'd15]} && data_byte != 8'd0)
                            flags_next = 1'b1;
                    end
                    pcnt_next = pcnt_reg + 16'd1;
                    if (pcnt_next >= len_reg)
                        done = 1'b1;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            if (done)
            begin
                case (type_next)
                    TYPE_FLAGS:
                    begin
                        if (len_next < FLAGS_MIN_LEN)
                            msg_status = ST_FLAGS_SHORT;
                        else if (flags_next)
                            msg_status = ST_INCOMPAT;
                    end
                    TYPE_SUB:
                    begin
                        if (len_next < SUB_MIN_LEN)
                            msg_status = ST_SUB_SHORT;
                        else
                        begin
                            msg_id   = id_next;
                            msg_inst = inst_next;
                        end
                    end
                    TYPE_DATA:
                    begin
                        if (len_next < DATA_MIN_LEN)
                            msg_status = ST_DATA_SHORT;
                        else
                            msg_id = id_next;
                    end
                    TYPE_DROPOUT:
                    begin
                        if (drop_reg != '1)
                            drop_next = drop_reg + 32'd1;
                    end
                    default:
                    begin
                    end
                endcase
                phase_next = PH_LEN0;
            end

            err = hdr_err || (done && msg_status != ST_OK);

            if (hdr_err)
            begin
                rpt.kind   = 1'b1;
                rpt.status = {1'b0, fault_next};
            end
            else
            begin
                rpt.kind        = (msg_status != ST_OK);
                rpt.msg_type    = type_next;
                rpt.length      = len_next;
                rpt.msg_id      = msg_id;
                rpt.instance_id = msg_inst;
                rpt.status      = msg_status;
            end
            rpt.dropouts = drop_next;

            // end-of-file summary, judged on the phase after this byte
            have_sum     = end_of_file && !err;
            sum.kind     = 1'b1;
            sum.dropouts = drop_next;
            sum.last     = 1'b1;
            if (phase_next == PH_HEADER)
                sum.status = ST_BAD_MAGIC;
            else if (phase_next == PH_PAYLOAD)
            begin
                sum.status   = ST_TRUNCATED;
                sum.msg_type = type_next;
                sum.length   = len_next;
            end
            else
                sum.status = ST_OK;

            if ((done || hdr_err) && have_sum)
            begin
                wr.count  = 2'd2;
                wr.first  = rpt;
                wr.second = sum;
            end
            else if (done || hdr_err)
            begin
                rpt.last = 1'b1;
                wr.count = 2'd1;
                wr.first = rpt;
            end
            else if (have_sum)
            begin
                wr.count = 2'd1;
                wr.first = sum;
            end

            if (err && !end_of_file)
                failed_next = 1'b1;
        end

        // any end-of-file byte starts a fresh file
        if (take && end_of_file)
        begin
            phase_next  = PH_HEADER;
            hidx_next   = '0;
            len_next    = '0;
            type_next   = '0;
            pcnt_next   = '0;
            id_next     = '0;
            inst_next   = '0;
            flags_next  = 1'b0;
            drop_next   = '0;
            failed_next = 1'b0;
            fault_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            pcnt_reg   <= '0;
            id_reg     <= '0;
            inst_reg   <= '0;
            flags_reg  <= 1'b0;
            drop_reg   <= '0;
            failed_reg <= 1'b0;
            fault_reg  <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            pcnt_reg   <= pcnt_next;
            id_reg     <= id_next;
            inst_reg   <= inst_next;
            flags_reg  <= flags_next;
            drop_reg   <= drop_next;
            failed_reg <= failed_next;
            fault_reg  <= fault_next;
        end
    end

endmodule

### rtl/lmsd_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
module lmsd_result_fifo
    import lmsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lmsd_wr_t     wr,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output lmsd_result_t out_data
);

    lmsd_result_t        mem [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                pop;

    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next = wptr_reg + QPTR_W'(wr.count);
        rptr_next = rptr_reg + QPTR_W'(pop);
        cnt_next  = cnt_reg + QCNT_W'(wr.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
            mem[wptr_reg] <= wr.first;
        if (wr.count == 2'd2)
            mem[wptr_reg + 1'b1] <= wr.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### rtl/log_message_stream_deframer.sv
// Top level of the log message stream deframer.
//
// Channel   Dir  Carries
// s_*       in   one log file byte per item; tlast marks the last byte of the file
// m_*       out  message reports and end-of-file / error summaries;
//                tlast marks the last result caused by one input byte
//
// One byte is parsed per cycle: the parser state registers update in the
// accept cycle and its results land in a four-entry result queue, so a byte
// can be taken every cycle while the queue holds two or fewer results.
// A byte makes at most two results; the output drains one per cycle, so a
// stalled output stops input only once the queue holds three results or more.
// With an empty queue, results appear on m_* in the cycle after the byte that caused them.
// rst_n clears all parser state and empties the queue; any tlast byte also
// returns the parser to its start-of-file state.
module log_message_stream_deframer
    import lmsd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] message_type, [23:8] message_length, [39:24] message_id,
    // [47:40] instance_id, [50:48] status, [82:51] dropouts, [87:83] zero
    output logic [87:0] m_tdata,
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // final_res
);

    lmsd_wr_t     wr;
    lmsd_result_t res;
    logic         take;

    assign take = s_tvalid && s_tready;

    lmsd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .wr          (wr)
    );

    lmsd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // pack the result, first field lowest
    assign m_tdata = {5'd0, res.dropouts, res.status, res.instance_id,
                      res.msg_id, res.length, res.msg_type};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

### tb/tb.sv
// Self-checking testbench for log_message_stream_deframer with a built-in parser predictor.
module tb;
    import lmsd_pkg::*;

    localparam int unsigned HDR_LEN     = 16;
    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned RANDOM_BYTES = 48;

    // Ordinary message types that the block only skips by length
    localparam logic [7:0] TYPE_FORMAT = 8'h46;  // 'F'
    localparam logic [7:0] TYPE_INFO   = 8'h49;  // 'I'

    typedef enum logic [2:0] {
        SEG_HEADER,
        SEG_LEN_LO,
        SEG_LEN_HI,
        SEG_TYPE,
        SEG_BODY
    } parse_seg_t;

    typedef enum logic [1:0] {
        HDR_GOOD,
        HDR_BAD_MAGIC,
        HDR_BAD_VERSION,
        HDR_BAD_BOTH
    } hdr_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    log_message_stream_deframer #(
        .HEADER_BYTES (HDR_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser predictor: mirrors the deframer state one byte at a time
    // ------------------------------------------------------------------
    parse_seg_t   seg;
    logic [3:0]   hdr_pos;
    logic [2:0]   hdr_fault;     // ST_OK, ST_BAD_MAGIC or ST_BAD_VERSION
    logic [15:0]  frame_len;
    logic [7:0]   frame_type;
    logic [15:0]  body_cnt;
    logic [15:0]  frame_id;
    logic [7:0]   frame_inst;
    logic         flag_bits_set;
    logic [31:0]  lost_count;
    logic         halted;        // error seen, skipping to end of file

    lmsd_result_t pending_reports[$];

    function automatic void start_of_file();
        seg           = SEG_HEADER;
        hdr_pos       = '0;
        hdr_fault     = ST_OK;
        frame_len     = '0;
        frame_type    = '0;
        body_cnt      = '0;
        frame_id      = '0;
        frame_inst    = '0;
        flag_bits_set = 1'b0;
        lost_count    = '0;
        halted        = 1'b0;
    endfunction

    function automatic lmsd_result_t report(input logic kind, input logic [7:0] msg_type,
                                            input logic [15:0] len, input logic [15:0] id,
                                            input logic [7:0] inst, input logic [2:0] st);
        lmsd_result_t r;
        r.kind        = kind;
        r.msg_type    = msg_type;
        r.length      = len;
        r.msg_id      = id;
        r.instance_id = inst;
        r.status      = st;
        r.dropouts    = lost_count;
        r.last        = 1'b0;
        return r;
    endfunction

    // Closes the current message; error reports carry the message type and length, kind 1
    function automatic lmsd_result_t finish_message();
        logic [2:0]  st;
        logic [15:0] id;
        logic [7:0]  inst;
        st   = ST_OK;
        id   = '0;
        inst = '0;
        case (frame_type)
            TYPE_FLAGS:
                if (frame_len < FLAGS_MIN_LEN)
                    st = ST_FLAGS_SHORT;
                else if (flag_bits_set)
                    st = ST_INCOMPAT;
            TYPE_SUB:
                if (frame_len < SUB_MIN_LEN)
                    st = ST_SUB_SHORT;
                else
                begin
                    id   = frame_id;
                    inst = frame_inst;
                end
            TYPE_DATA:
                if (frame_len < DATA_MIN_LEN)
                    st = ST_DATA_SHORT;
                else
                    id = frame_id;
            TYPE_DROPOUT:
                if (lost_count != 32'hFFFF_FFFF)
                    lost_count = lost_count + 32'd1;
            default: ;
        endcase
        seg = SEG_LEN_LO;
        return report(st != ST_OK, frame_type, frame_len, id, inst, st);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic eof);
        lmsd_result_t out[$];
        lmsd_result_t r;
        logic         err;
        int unsigned  idx;
        err = 1'b0;
        if (halted)
        begin
            if (eof)
                start_of_file();
            return;
        end
        case (seg)
            SEG_HEADER:
            begin
                idx = 32'(hdr_pos);
                if (idx < MAGIC_BYTES)
                begin
                    if (b != MAGIC[idx] && hdr_fault == ST_OK)
                        hdr_fault = ST_BAD_MAGIC;
                end
                else if (idx == MAGIC_BYTES && b != LOG_VERSION && hdr_fault == ST_OK)
                    hdr_fault = ST_BAD_VERSION;
                if (idx + 1 >= HDR_LEN)
                begin
                    if (hdr_fault != ST_OK)
                    begin
                        out = {out, report(1'b1, '0, '0, '0, '0, hdr_fault)};
                        err = 1'b1;
                    end
                    else
                        seg = SEG_LEN_LO;
                end
                else
                    hdr_pos = 4'(idx + 1);
            end
            SEG_LEN_LO:
            begin
                frame_len = {8'h00, b};
                seg       = SEG_LEN_HI;
            end
            SEG_LEN_HI:
            begin
                frame_len[15:8] = b;
                seg             = SEG_TYPE;
            end
            SEG_TYPE:
            begin
                frame_type    = b;
                body_cnt      = '0;
                frame_id      = '0;
                frame_inst    = '0;
                flag_bits_set = 1'b0;
                if (frame_len == 0)
                begin
                    r = finish_message();
                    out = {out, r};
                    err = (r.status != ST_OK);
                end
                else
                    seg = SEG_BODY;
            end
            default:
            begin
                // Capture the id fields and the incompatible-flags word
                if (frame_type == TYPE_SUB)
                begin
                    if (body_cnt == 0)
                        frame_inst = b;
                    else if (body_cnt == 1)
                        frame_id[7:0] = b;
                    else if (body_cnt == 2)
                        frame_id[15:8] = b;
                end
                else if (frame_type == TYPE_DATA)
                begin
                    if (body_cnt == 0)
                        frame_id[7:0] = b;
                    else if (body_cnt == 1)
                        frame_id[15:8] = b;
                end
                else if (frame_type == TYPE_FLAGS)
                begin
                    if (body_cnt >= 8 && body_cnt < 16 && b != 8'h00)
                        flag_bits_set = 1'b1;
                end
                body_cnt = body_cnt + 16'd1;
                if (body_cnt >= frame_len)
                begin
                    r = finish_message();
                    out = {out, r};
                    err = (r.status != ST_OK);
                end
            end
        endcase

        if (eof && !err)
        begin
            if (seg == SEG_HEADER)
                out = {out, report(1'b1, '0, '0, '0, '0, ST_BAD_MAGIC)};
            else if (seg == SEG_BODY)
                out = {out, report(1'b1, frame_type, frame_len, '0, '0, ST_TRUNCATED)};
            else
                out = {out, report(1'b1, '0, '0, '0, '0, ST_OK)};
        end

        if (out.size() > 0)
            out[out.size() - 1].last = 1'b1;
        foreach (out[i])
            pending_reports = {pending_reports, out[i]};

        if (eof)
            start_of_file();
        else if (err)
            halted = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    int unsigned bad_results = 0;

    always @(posedge clk)
    begin
        lmsd_result_t want;
        lmsd_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.msg_type    = m_tdata[7:0];
            got.length      = m_tdata[23:8];
            got.msg_id      = m_tdata[39:24];
            got.instance_id = m_tdata[47:40];
            got.status      = m_tdata[50:48];
            got.dropouts    = m_tdata[82:51];
            got.kind        = m_tuser;
            got.last        = m_tlast;
            if (pending_reports.size() == 0)
            begin
                if (bad_results < 10)
                    $display("unexpected result: kind=%0d type=%02h len=%0d st=%0d",
                             got.kind, got.msg_type, got.length, got.status);
                bad_results++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want || m_tdata[87:83] !== 5'd0)
                begin
                    if (bad_results < 10)
                    begin
                        $display("exp: k=%0d t=%02h l=%0d id=%0d in=%0d st=%0d dr=%0d lt=%0d",
                                 want.kind, want.msg_type, want.length, want.msg_id,
                                 want.instance_id, want.status, want.dropouts, want.last);
                        $display("got: k=%0d t=%02h l=%0d id=%0d in=%0d st=%0d dr=%0d lt=%0d p=%0h",
                                 got.kind, got.msg_type, got.length, got.msg_id,
                                 got.instance_id, got.status, got.dropouts, got.last,
                                 m_tdata[87:83]);
                    end
                    bad_results++;
                end
            end
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("log_message_stream_deframer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output backpressure: random stalls, each held for a random length of time
    // ------------------------------------------------------------------
    int unsigned rx_stall_pct = 0;
    int unsigned rx_hold = 0;

    always @(negedge clk)
    begin
        if (rx_hold != 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
        begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(0, 3);
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length with random gaps when enabled
    // ------------------------------------------------------------------
    logic        gaps_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    logic [7:0]  file_q[$];   // log file under construction

    function automatic void put_byte(input logic [7:0] b);
        file_q = {file_q, b};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do
            @(posedge clk);
        while (!s_tready);
        parse_byte(b, eof);
        bytes_sent++;
    endtask

    // Sends the first keep bytes of the built file, the last one flagged end of file
    task automatic send_file(input int unsigned keep);
        for (int unsigned i = 0; i < keep; i++)
            send_byte(file_q[i], i == keep - 1);
        file_q.delete();
    endtask

    task automatic put_header(input hdr_kind_t k);
        logic [7:0]  b;
        int unsigned bad_pos;
        bad_pos = $urandom_range(0, MAGIC_BYTES - 1);
        for (int unsigned i = 0; i < HDR_LEN; i++)
        begin
            if (i < MAGIC_BYTES)
                b = MAGIC[i];
            else if (i == MAGIC_BYTES)
                b = LOG_VERSION;
            else
                b = 8'($urandom);
            if ((k == HDR_BAD_MAGIC || k == HDR_BAD_BOTH) && i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            if ((k == HDR_BAD_VERSION || k == HDR_BAD_BOTH) && i == MAGIC_BYTES)
                b = b ^ 8'($urandom_range(1, 255));
            put_byte(b);
        end
    endtask

    // One message; a dirty flags message gets one nonzero incompatible-flags byte when its payload is long enough
    task automatic put_msg(input logic [7:0] msg_type, input int unsigned len,
                           input logic dirty);
        logic [15:0] l;
        int unsigned spot;
        l    = 16'(len);
        spot = $urandom_range(8, 15);
        put_byte(l[7:0]);
        put_byte(l[15:8]);
        put_byte(msg_type);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (msg_type == TYPE_FLAGS && i >= 8 && i < 16)
                put_byte((dirty && i == spot) ? 8'($urandom_range(1, 255)) : 8'h00);
            else
                put_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Well-formed files: every special type, zero-length messages, dropout counting
    task automatic test_clean_files();
        gaps_on      = 1'b0;
        rx_stall_pct = 0;
        put_header(HDR_GOOD);
        put_msg(TYPE_FLAGS, 40, 1'b0);
        put_msg(TYPE_SUB, 3, 1'b0);
        put_msg(TYPE_SUB, 7, 1'b0);
        put_msg(TYPE_DATA, 2, 1'b0);
        put_msg(TYPE_DATA, 9, 1'b0);
        put_msg(TYPE_DROPOUT, 2, 1'b0);
        put_msg(TYPE_DROPOUT, 0, 1'b0);
        put_msg(TYPE_FORMAT, 5, 1'b0);
        put_msg(8'hFF, 0, 1'b0);
        put_msg(8'h00, 1, 1'b0);
        put_msg(TYPE_DATA, 12, 1'b0);
        send_file(file_q.size());
        // Dropout count restarts with a new file
        put_header(HDR_GOOD);
        put_msg(TYPE_DROPOUT, 0, 1'b0);
        send_file(file_q.size());
    endtask

    // Magic and version faults, short files, a file that ends with the header
    task automatic test_header_faults();
        gaps_on      = 1'b1;
        rx_stall_pct = 0;
        put_header(HDR_BAD_MAGIC);
        put_msg(TYPE_DATA, 4, 1'b0);
        send_file(file_q.size());
        put_header(HDR_BAD_VERSION);
        put_msg(TYPE_SUB, 4, 1'b0);
        send_file(file_q.size());
        put_header(HDR_BAD_BOTH);      // magic wins
        send_file(file_q.size());
        put_byte(MAGIC[0]);            // one-byte file
        send_file(1);
        put_header(HDR_GOOD);
        send_file(9);                  // ends inside the header
        put_header(HDR_GOOD);
        send_file(HDR_LEN);            // ends right after a clean header
    endtask

    // Minimum-size and incompatible-flags errors, then skipping to end of file
    task automatic test_message_errors();
        gaps_on      = 1'b0;
        rx_stall_pct = 50;
        put_header(HDR_GOOD);
        put_msg(TYPE_FLAGS, 39, 1'b0);
        put_msg(TYPE_DATA, 4, 1'b0);
        send_file(file_q.size());
        put_header(HDR_GOOD);
        put_msg(TYPE_FLAGS, 40, 1'b1);
        put_msg(TYPE_DATA, 4, 1'b0);
        send_file(file_q.size());
        put_header(HDR_GOOD);
        put_msg(TYPE_SUB, 2, 1'b0);
        put_msg(TYPE_SUB, 5, 1'b0);
        send_file(file_q.size());
        put_header(HDR_GOOD);
        put_msg(TYPE_DATA, 1, 1'b0);
        put_msg(TYPE_DATA, 3, 1'b0);
        send_file(file_q.size());
        put_header(HDR_GOOD);
        put_msg(TYPE_SUB, 0, 1'b0);
        send_file(file_q.size());
        // Error on the end-of-file byte itself: no summary follows
        put_header(HDR_GOOD);
        put_msg(TYPE_DATA, 0, 1'b0);
        send_file(file_q.size());
    endtask

    // End of file inside and right after the length field, after the type byte and mid-payload
    task automatic test_truncation();
        gaps_on      = 1'b1;
        rx_stall_pct = 30;
        put_header(HDR_GOOD);
        put_msg(TYPE_DATA, 5, 1'b0);
        send_file(HDR_LEN + 1);
        put_header(HDR_GOOD);
        put_msg(TYPE_DATA, 5, 1'b0);
        send_file(HDR_LEN + 2);
        put_header(HDR_GOOD);
        put_msg(TYPE_DATA, 5, 1'b0);
        send_file(HDR_LEN + 3);
        put_header(HDR_GOOD);
        put_msg(TYPE_SUB, 10, 1'b0);
        send_file(HDR_LEN + 7);
        // Largest length field
        put_header(HDR_GOOD);
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_byte(TYPE_DATA);
        repeat (6) put_byte(8'($urandom));
        send_file(file_q.size());
    endtask

    // Random files, mostly well formed, some noise, some cut short
    task automatic test_random_files();
        int unsigned start;
        int unsigned keep;
        int unsigned len;
        logic [7:0]  msg_type;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 25;
                default: rx_stall_pct = 60;
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    put_header(hdr_kind_t'($urandom_range(1, 3)));
                else
                    put_header(HDR_GOOD);
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            msg_type = TYPE_FLAGS;
                            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 39)
                                                              : $urandom_range(38, 44);
                        end
                        1:
                        begin
                            msg_type = TYPE_SUB;
                            len      = $urandom_range(0, 6);
                        end
                        2:
                        begin
                            msg_type = TYPE_DATA;
                            len      = $urandom_range(0, 8);
                        end
                        3:
                        begin
                            msg_type = TYPE_DROPOUT;
                            len      = $urandom_range(0, 3);
                        end
                        4:
                        begin
                            msg_type = TYPE_FORMAT;
                            len      = $urandom_range(0, 16);
                        end
                        5:
                        begin
                            msg_type = TYPE_INFO;
                            len      = $urandom_range(0, 16);
                        end
                        default:
                        begin
                            msg_type = 8'($urandom);
                            len      = $urandom_range(0, 12);
                        end
                    endcase
                    if ($urandom_range(0, 19) == 0)
                        len = $urandom_range(40, 200);
                    put_msg(msg_type, len, $urandom_range(0, 4) == 0);
                end
            end
            keep = file_q.size();
            if ($urandom_range(0, 3) == 0)
                keep = $urandom_range(1, file_q.size());
            send_file(keep);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        start_of_file();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_clean_files();
        test_header_faults();
        test_message_errors();
        test_truncation();
        test_random_files();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (bad_results == 0 && pending_reports.size() == 0)
            $display("log_message_stream_deframer verification clean");
        else
            $display("log_message_stream_deframer verification failed");
        $finish;
    end

endmodule
